// ===== rtl/sft_pkg.sv =====
// sft_pkg: shared constants, field widths and types for the sparse fast transpose
// used by sft_entry_store, sft_col_unit and sparse_triplet_fast_transpose
// no dependencies
package sft_pkg;

    localparam int DEF_MAX_TERMS = 64;
    localparam int DEF_MAX_DIM   = 256;

    localparam int IDX_W      = 9;
    localparam int VAL_W      = 32;
    localparam int TDATA_W    = 56;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    // one stored triplet
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        row;
    } entry_t;

    // operations of the column unit
    typedef enum logic [2:0] {
        COL_NONE   = 3'd0,
        COL_READ   = 3'd1,
        COL_CLEAR  = 3'd2,
        COL_INC    = 3'd3,
        COL_PREFIX = 3'd4,
        COL_BUMP   = 3'd5
    } col_op_t;

endpackage

// ===== rtl/sft_entry_store.sv =====
// sft_entry_store: triplet memory, one write port and one registered read port
// depends on sft_pkg (entry_t)
module sft_entry_store
    import sft_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    localparam int TERM_AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [TERM_AW-1:0]    wr_addr,
    input  entry_t                wr_data,
    input  logic [TERM_AW-1:0]    rd_addr,
    output entry_t                rd_data
);

    entry_t mem [MAX_TERMS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sft_col_unit.sv =====
// sft_col_unit: per-column count and start memories with the shared adder
// that does count increments, the running prefix sum and slot bumps
// depends on sft_pkg (col_op_t)
module sft_col_unit
    import sft_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int MAX_DIM   = DEF_MAX_DIM,
    localparam int CNT_W    = $clog2(MAX_TERMS + 1),
    localparam int DIM_AW   = $clog2(MAX_DIM)
)
(
    input  logic               clk,
    input  col_op_t            op,
    input  logic [DIM_AW-1:0]  addr,
    output logic [CNT_W-1:0]   rd_start
);

    logic [CNT_W-1:0] count_mem [MAX_DIM];
    logic [CNT_W-1:0] start_mem [MAX_DIM];
    logic [CNT_W-1:0] rd_count_reg;
    logic [CNT_W-1:0] rd_start_reg;
    logic [CNT_W-1:0] sum_reg;
    logic [CNT_W-1:0] sum_base;
    logic [CNT_W-1:0] add_a;
    logic [CNT_W-1:0] add_b;
    logic [CNT_W-1:0] add_y;

    // the prefix pass starts from zero at the first column
    assign sum_base = (addr == '0) ? '0 : sum_reg;

    always_comb
    begin
        case (op)
            COL_INC:
            begin
                add_a = rd_count_reg;
                add_b = CNT_W'(1);
            end
            COL_PREFIX:
            begin
                add_a = sum_base;
                add_b = rd_count_reg;
            end
            COL_BUMP:
            begin
                add_a = rd_start_reg;
                add_b = CNT_W'(1);
            end
            default:
            begin
                add_a = rd_count_reg;
                add_b = '0;
            end
        endcase
    end

    assign add_y = add_a + add_b;

    always_ff @(posedge clk)
    begin
        rd_count_reg <= count_mem[addr];
        rd_start_reg <= start_mem[addr];
        case (op)
            COL_CLEAR:
            begin
                count_mem[addr] <= '0;
            end
            COL_INC:
            begin
                count_mem[addr] <= add_y;
            end
            COL_PREFIX:
            begin
                // count is zeroed as it is consumed, ready for the next matrix
                count_mem[addr] <= '0;
                start_mem[addr] <= sum_base;
            end
            COL_BUMP:
            begin
                start_mem[addr] <= add_y;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op == COL_PREFIX)
        begin
            sum_reg <= add_y;
        end
    end

    assign rd_start = rd_start_reg;

endmodule

// ===== rtl/sparse_triplet_fast_transpose.sv =====
// Sparse matrix fast transpose over (row, column, value) triplets. After reset the
// block clears the count of every one of its MAX_DIM columns and takes no triplet
// until then. Each triplet is loaded with a read-modify-write of its column count
// through the column unit; dropped triplets and bare markers skip that step. On the
// last item the block walks all MAX_DIM columns forming start positions, places each
// stored entry at its column slot and then emits the transposed triplets column by
// column, reading the next result only after the sink has taken the last one.
// Triplets whose column is 0, above col_count or above MAX_DIM, and triplets beyond
// MAX_TERMS, are dropped. row_count is accepted on the configuration channel but
// does not change the results. Configuration writes are taken in any cycle.
// depends on sft_pkg, sft_entry_store, sft_col_unit
module sparse_triplet_fast_transpose
    import sft_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int MAX_DIM   = DEF_MAX_DIM
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // src_row[8:0], src_col[17:9], entry_value[49:18]
    input  logic                  s_axis_tuser,   // has_entry
    input  logic                  s_axis_tlast,   // last_in

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // out_row[8:0], out_col[17:9], out_value[49:18]
    output logic                  m_axis_tlast,   // out_last

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W   = $clog2(MAX_TERMS + 1);
    localparam int TERM_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DIM_AW  = $clog2(MAX_DIM);
    localparam logic [DIM_AW-1:0] DIM_LAST = DIM_AW'(MAX_DIM - 1);

    typedef enum logic [10:0] {
        ST_INIT    = 11'b000_0000_0001,
        ST_IDLE    = 11'b000_0000_0010,
        ST_INC     = 11'b000_0000_0100,
        ST_PRE_RD  = 11'b000_0000_1000,
        ST_PRE_WR  = 11'b000_0001_0000,
        ST_SC_RD   = 11'b000_0010_0000,
        ST_SC_COL  = 11'b000_0100_0000,
        ST_SC_WR   = 11'b000_1000_0000,
        ST_EM_RD   = 11'b001_0000_0000,
        ST_EM_ST   = 11'b010_0000_0000,
        ST_EM_WAIT = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [DIM_AW-1:0]   dim_reg, dim_next;
    logic [DIM_AW-1:0]   col_addr_reg, col_addr_next;
    logic                last_reg, last_next;
    logic [IDX_W-1:0]    col_count_reg;
    logic                out_valid_reg;
    entry_t              out_entry_reg;
    logic                out_last_reg;
    logic                out_load;

    logic [TERM_AW-1:0]  slot_mem [MAX_TERMS];
    logic [TERM_AW-1:0]  slot_rd_reg;
    logic                slot_we;

    entry_t              in_entry;
    logic                in_fire;
    logic                col_ok;
    logic                load_ok;
    logic [DIM_AW-1:0]   in_col_addr;
    logic [DIM_AW-1:0]   st_col_addr;
    logic                k_is_last;

    logic                es_we;
    logic [TERM_AW-1:0]  es_raddr;
    entry_t              es_rdata;

    col_op_t             col_op;
    logic [DIM_AW-1:0]   col_addr;
    logic [CNT_W-1:0]    rd_start;

    assign in_entry.row   = s_axis_tdata[8:0];
    assign in_entry.col   = s_axis_tdata[17:9];
    assign in_entry.value = s_axis_tdata[49:18];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign col_ok  = (in_entry.col != '0) && (in_entry.col <= col_count_reg)
                     && (32'(in_entry.col) <= 32'(MAX_DIM));
    assign load_ok = s_axis_tuser && col_ok && (n_reg < CNT_W'(MAX_TERMS));

    assign in_col_addr = DIM_AW'(32'(in_entry.col) - 32'd1);
    assign st_col_addr = DIM_AW'(32'(es_rdata.col) - 32'd1);
    assign k_is_last   = (k_reg == n_reg - CNT_W'(1));

    sft_entry_store #(
        .MAX_TERMS (MAX_TERMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (es_we),
        .wr_addr (n_reg[TERM_AW-1:0]),
        .wr_data (in_entry),
        .rd_addr (es_raddr),
        .rd_data (es_rdata)
    );

    sft_col_unit #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_DIM   (MAX_DIM)
    ) u_col (
        .clk      (clk),
        .op       (col_op),
        .addr     (col_addr),
        .rd_start (rd_start)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        dim_next      = dim_reg;
        col_addr_next = col_addr_reg;
        last_next     = last_reg;
        col_op        = COL_NONE;
        col_addr      = col_addr_reg;
        es_we         = 1'b0;
        es_raddr      = k_reg[TERM_AW-1:0];
        slot_we       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                col_op   = COL_CLEAR;
                col_addr = dim_reg;
                if (dim_reg == DIM_LAST)
                begin
                    dim_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dim_next = dim_reg + DIM_AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = s_axis_tlast;
                    if (load_ok)
                    begin
                        es_we         = 1'b1;
                        col_op        = COL_READ;
                        col_addr      = in_col_addr;
                        col_addr_next = in_col_addr;
                        state_next    = ST_INC;
                    end
                    else if (s_axis_tlast && (n_reg != '0))
                    begin
                        dim_next   = '0;
                        state_next = ST_PRE_RD;
                    end
                end
            end
            ST_INC:
            begin
                col_op = COL_INC;
                n_next = n_reg + CNT_W'(1);
                if (last_reg)
                begin
                    dim_next   = '0;
                    state_next = ST_PRE_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRE_RD:
            begin
                col_op     = COL_READ;
                col_addr   = dim_reg;
                state_next = ST_PRE_WR;
            end
            ST_PRE_WR:
            begin
                col_op   = COL_PREFIX;
                col_addr = dim_reg;
                if (dim_reg == DIM_LAST)
                begin
                    dim_next   = '0;
                    k_next     = '0;
                    state_next = ST_SC_RD;
                end
                else
                begin
                    dim_next   = dim_reg + DIM_AW'(1);
                    state_next = ST_PRE_RD;
                end
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_COL;
            end
            ST_SC_COL:
            begin
                col_op        = COL_READ;
                col_addr      = st_col_addr;
                col_addr_next = st_col_addr;
                state_next    = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                // entry k goes to its column's next free slot
                col_op  = COL_BUMP;
                slot_we = 1'b1;
                if (k_is_last)
                begin
                    k_next     = '0;
                    state_next = ST_EM_RD;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_SC_RD;
                end
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_ST;
            end
            ST_EM_ST:
            begin
                es_raddr   = slot_rd_reg;
                state_next = ST_EM_WAIT;
            end
            ST_EM_WAIT:
            begin
                // first cycle here loads the output register, then wait for the sink
                if (!out_valid_reg)
                begin
                    out_load = 1'b1;
                end
                else if (m_axis_tready)
                begin
                    if (out_last_reg)
                    begin
                        n_next     = '0;
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            n_reg         <= '0;
            k_reg         <= '0;
            dim_reg       <= '0;
            col_addr_reg  <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            col_count_reg <= IDX_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
            dim_reg      <= dim_next;
            col_addr_reg <= col_addr_next;
            last_reg     <= last_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // row count has no effect on the ordering, only column count is kept
            if (cfg_valid && (cfg_index == CFG_COL_COUNT))
            begin
                col_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_entry_reg <= es_rdata;
            out_last_reg  <= k_is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[rd_start[TERM_AW-1:0]] <= k_reg[TERM_AW-1:0];
        end
        slot_rd_reg <= slot_mem[k_reg[TERM_AW-1:0]];
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'b0, out_entry_reg.value, out_entry_reg.row, out_entry_reg.col};

endmodule
